[sv/crce_pkg.sv]
// Package for the Catmull-Rom curve evaluator: widths, constants, payload
// types, the controller state type and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps

package crce_pkg;

    localparam int MAX_POINTS      = 256;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int WFRAC           = 24;

    localparam int COORD_W  = 32;
    localparam int IDX_W    = 8;
    localparam int ADDR_W   = $clog2(MAX_POINTS);
    localparam int CNT_W    = 9;
    localparam int U_W      = PARAM_FRAC_BITS + 1;
    localparam int N_W      = ADDR_W;
    localparam int UPROD_W  = U_W + N_W;
    localparam int SEG_W    = UPROD_W - PARAM_FRAC_BITS;
    localparam int T_W      = WFRAC + 1;
    localparam int SQ_W     = 2 * T_W;
    localparam int W_W      = WFRAC + 4;
    localparam int PROD_W   = W_W + COORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int RND_W    = ACC_W - (WFRAC + 1);
    localparam int RAM_W    = 3 * COORD_W;
    localparam int NTAPS    = 4;
    localparam int K_W      = 2;

    localparam int CNT_RESET = 4;
    localparam int CNT_MIN   = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic [U_W-1:0]            u;
    } crce_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      clipped;
    } crce_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SQ,
        ST_CUBE,
        ST_WGT,
        ST_FETCH,
        ST_DRAIN,
        ST_ROUND
    } crce_state_t;

    typedef struct packed {
        logic           wr_en;
        logic           prod_load;
        logic           map_load;
        logic           sq_load;
        logic           cube_load;
        logic           wgt_load;
        logic           acc_clr;
        logic           rd_en;
        logic [K_W-1:0] rd_k;
        logic           mul_en;
        logic [K_W-1:0] mul_k;
        logic           acc_en;
        logic           out_load;
    } crce_cmd_t;

endpackage

[sv/crce_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/crce_ctrl.sv]
// Sequencing controller for the curve evaluator.
// Depends on crce_pkg.
`timescale 1ns / 1ps

module crce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    output logic                busy,
    output crce_pkg::crce_cmd_t cmd
);

    crce_pkg::crce_state_t      state_reg, state_next;
    logic [crce_pkg::K_W-1:0]   k_reg, k_next;
    logic                       mul_v_reg, mul_v_next;
    logic [crce_pkg::K_W-1:0]   mul_k_reg, mul_k_next;
    logic                       acc_v_reg, acc_v_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crce_pkg::ST_IDLE;
            k_reg     <= '0;
            mul_v_reg <= 1'b0;
            mul_k_reg <= '0;
            acc_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            mul_v_reg <= mul_v_next;
            mul_k_reg <= mul_k_next;
            acc_v_reg <= acc_v_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.wr_en     = accept && (op == crce_pkg::OP_WRITE);
        cmd.mul_en    = mul_v_reg;
        cmd.mul_k     = mul_k_reg;
        cmd.acc_en    = acc_v_reg;
        case (state_reg)
            crce_pkg::ST_IDLE:
            begin
                if (accept && (op == crce_pkg::OP_EVAL))
                begin
                    cmd.prod_load = 1'b1;
                    state_next    = crce_pkg::ST_MAP;
                end
            end
            crce_pkg::ST_MAP:
            begin
                cmd.map_load = 1'b1;
                state_next   = crce_pkg::ST_SQ;
            end
            crce_pkg::ST_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next  = crce_pkg::ST_CUBE;
            end
            crce_pkg::ST_CUBE:
            begin
                cmd.cube_load = 1'b1;
                state_next    = crce_pkg::ST_WGT;
            end
            crce_pkg::ST_WGT:
            begin
                cmd.wgt_load = 1'b1;
                cmd.acc_clr  = 1'b1;
                k_next       = '0;
                state_next   = crce_pkg::ST_FETCH;
            end
            crce_pkg::ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
                cmd.rd_k  = k_reg;
                k_next    = k_reg + 1'b1;
                if (k_reg == crce_pkg::K_W'(crce_pkg::NTAPS - 1))
                begin
                    k_next     = '0;
                    state_next = crce_pkg::ST_DRAIN;
                end
            end
            crce_pkg::ST_DRAIN:
            begin
                // last product, then last accumulate
                k_next = k_reg + 1'b1;
                if (k_reg == crce_pkg::K_W'(1))
                begin
                    state_next = crce_pkg::ST_ROUND;
                end
            end
            crce_pkg::ST_ROUND:
            begin
                cmd.out_load = 1'b1;
                state_next   = crce_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crce_pkg::ST_IDLE;
            end
        endcase
        mul_v_next = cmd.rd_en;
        mul_k_next = cmd.rd_k;
        acc_v_next = mul_v_reg;
    end

    assign busy = (state_reg != crce_pkg::ST_IDLE);

endmodule

[sv/crce_dp.sv]
// Datapath: point table, segment mapping, basis weights, three-axis MAC,
// rounding and saturation, point_count register.
// Depends on crce_pkg and crce_ram.
`timescale 1ns / 1ps

module crce_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  crce_pkg::crce_cmd_t              cmd,
    input  crce_pkg::crce_item_t             item,
    input  logic                             cfg_we,
    input  logic [crce_pkg::CNT_W-1:0]       cfg_wdata,
    output logic                             done,
    output crce_pkg::crce_result_t           result
);

    localparam int F  = crce_pkg::PARAM_FRAC_BITS;
    localparam int WF = crce_pkg::WFRAC;

    logic [crce_pkg::CNT_W-1:0]   count_reg;
    logic [crce_pkg::CNT_W-1:0]   count_c;
    logic [crce_pkg::N_W-1:0]     n_c;
    logic [crce_pkg::N_W-1:0]     n_reg;
    logic [crce_pkg::UPROD_W-1:0] uprod_reg;
    logic [crce_pkg::SEG_W-1:0]   seg;
    logic [crce_pkg::ADDR_W-1:0]  base_reg;
    logic [crce_pkg::T_W-1:0]     t_reg;
    logic [crce_pkg::T_W-1:0]     t2_reg;
    logic [crce_pkg::T_W-1:0]     t3_reg;
    logic [crce_pkg::SQ_W-1:0]    sq_sum;
    logic [crce_pkg::SQ_W-1:0]    cube_sum;
    logic signed [crce_pkg::W_W-1:0] ts, t2s, t3s;
    logic signed [crce_pkg::W_W-1:0] w_reg [crce_pkg::NTAPS];
    logic signed [crce_pkg::W_W-1:0] w_sel;
    logic signed [crce_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [crce_pkg::ACC_W-1:0]  acc_reg [3];
    logic signed [crce_pkg::COORD_W-1:0] sat_val [3];
    logic [2:0]                   sat_clip;
    logic [crce_pkg::ADDR_W-1:0]  ram_addr;
    logic [crce_pkg::RAM_W-1:0]   ram_rdata;
    logic                         done_reg;
    crce_pkg::crce_result_t       result_reg;

    // point_count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= crce_pkg::CNT_W'(crce_pkg::CNT_RESET);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        count_c = count_reg;
        if (count_reg < crce_pkg::CNT_W'(crce_pkg::CNT_MIN))
        begin
            count_c = crce_pkg::CNT_W'(crce_pkg::CNT_MIN);
        end
        else if (count_reg > crce_pkg::CNT_W'(crce_pkg::MAX_POINTS))
        begin
            count_c = crce_pkg::CNT_W'(crce_pkg::MAX_POINTS);
        end
    end
    assign n_c = crce_pkg::N_W'(count_c - crce_pkg::CNT_W'(3));

    // point table, {z, y, x}
    assign ram_addr = cmd.wr_en ? crce_pkg::ADDR_W'(item.point_index)
                                : base_reg + crce_pkg::ADDR_W'(cmd.rd_k);

    crce_ram #(
        .WIDTH (crce_pkg::RAM_W),
        .DEPTH (crce_pkg::MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en),
        .addr  (ram_addr),
        .wdata ({item.in_z, item.in_y, item.in_x}),
        .rdata (ram_rdata)
    );

    // segment and fraction
    assign seg = uprod_reg[crce_pkg::UPROD_W-1:F];

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            uprod_reg <= crce_pkg::UPROD_W'(item.u) * crce_pkg::UPROD_W'(n_c);
            n_reg     <= n_c;
        end
        if (cmd.map_load)
        begin
            if (seg >= crce_pkg::SEG_W'(n_reg))
            begin
                base_reg <= n_reg - crce_pkg::N_W'(1);
                t_reg    <= crce_pkg::T_W'(1) << WF;
            end
            else
            begin
                base_reg <= crce_pkg::ADDR_W'(seg);
                t_reg    <= crce_pkg::T_W'(uprod_reg[F-1:0]) << (WF - F);
            end
        end
    end

    // t^2 and t^3, rounded to Q1.24
    assign sq_sum   = crce_pkg::SQ_W'(t_reg) * crce_pkg::SQ_W'(t_reg)
                    + (crce_pkg::SQ_W'(1) << (WF - 1));
    assign cube_sum = crce_pkg::SQ_W'(t2_reg) * crce_pkg::SQ_W'(t_reg)
                    + (crce_pkg::SQ_W'(1) << (WF - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            t2_reg <= sq_sum[WF +: crce_pkg::T_W];
        end
        if (cmd.cube_load)
        begin
            t3_reg <= cube_sum[WF +: crce_pkg::T_W];
        end
    end

    // doubled basis weights
    assign ts  = signed'(crce_pkg::W_W'(t_reg));
    assign t2s = signed'(crce_pkg::W_W'(t2_reg));
    assign t3s = signed'(crce_pkg::W_W'(t3_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.wgt_load)
        begin
            w_reg[0] <= (t2s <<< 1) - t3s - ts;
            w_reg[1] <= (t3s <<< 1) + t3s - (t2s <<< 2) - t2s
                        + signed'(crce_pkg::W_W'(2) << WF);
            w_reg[2] <= (t2s <<< 2) + ts - (t3s <<< 1) - t3s;
            w_reg[3] <= t3s - t2s;
        end
    end

    // per-axis multiply, then accumulate
    assign w_sel = w_reg[cmd.mul_k];

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (cmd.mul_en)
            begin
                prod_reg[a] <= crce_pkg::PROD_W'(w_sel)
                             * crce_pkg::PROD_W'(signed'(
                                   ram_rdata[a*crce_pkg::COORD_W +: crce_pkg::COORD_W]));
            end
            if (cmd.acc_clr)
            begin
                acc_reg[a] <= '0;
            end
            else if (cmd.acc_en)
            begin
                acc_reg[a] <= acc_reg[a] + crce_pkg::ACC_W'(prod_reg[a]);
            end
        end
    end

    // round half up by 2^25, then saturate to 32 bits
    always_comb
    begin
        logic signed [crce_pkg::ACC_W-1:0] rsum;
        logic signed [crce_pkg::RND_W-1:0] r;
        for (int a = 0; a < 3; a++)
        begin
            rsum = acc_reg[a] + (crce_pkg::ACC_W'(1) <<< WF);
            r    = rsum[crce_pkg::ACC_W-1:WF+1];
            sat_val[a]  = r[crce_pkg::COORD_W-1:0];
            sat_clip[a] = 1'b0;
            if (r > crce_pkg::RND_W'(32'sh7fffffff))
            begin
                sat_val[a]  = 32'sh7fffffff;
                sat_clip[a] = 1'b1;
            end
            else if (r < -(crce_pkg::RND_W'(33'sh080000000)))
            begin
                sat_val[a]  = 32'sh80000000;
                sat_clip[a] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.out_x   <= sat_val[0];
            result_reg.out_y   <= sat_val[1];
            result_reg.out_z   <= sat_val[2];
            result_reg.clipped <= |sat_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_load;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/catmull_rom_curve_eval_top.sv]
// Top level of the uniform Catmull-Rom 3-D curve evaluator.
// Depends on crce_pkg, crce_ctrl, crce_dp (and crce_ram through crce_dp).
`timescale 1ns / 1ps

// Usage
//   Input channel: drive item and raise start; the transaction is taken at the
//   rising edge where start is high and busy is low.
//   item.op = write: stores (in_x, in_y, in_z) at table slot point_index in
//     that same cycle. busy never rises, so a new transaction may follow in
//     the next cycle.
//   item.op = evaluate: maps u onto segment and fraction, weights four
//     neighboring points with the Catmull-Rom basis and returns one result.
//     busy stays high while the evaluation runs; done pulses for one cycle
//     in the cycle where busy falls again, with result valid only then.
//     The next transaction may be accepted in that same cycle. The table
//     reads fetch one point per cycle from the single-port table; the
//     other states are the segment mapping, the t^2 / t^3 / weight chain,
//     the multiply-accumulate drain and the output rounding.
//   Result channel: done strobes exactly once per evaluation; the receiver
//     cannot stall it and must take the result in that cycle.
//   Configuration: cfg_we / cfg_wdata write point_count; write it only while
//     idle. Values below 4 act as 4, above 256 act as 256.
//   Reset: rst_n (async, active low) returns to idle, clears done and sets
//     point_count to 4. The table is not cleared: read only written points.

module catmull_rom_curve_eval_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  crce_pkg::crce_item_t          item,
    output logic                          done,
    output crce_pkg::crce_result_t        result,
    input  logic                          cfg_we,
    input  logic [crce_pkg::CNT_W-1:0]    cfg_wdata
);

    crce_pkg::crce_cmd_t cmd;
    logic                accept;

    // busy comes straight from the controller state register
    assign accept = start && !busy;

    crce_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (item.op),
        .busy   (busy),
        .cmd    (cmd)
    );

    crce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

endmodule

[sv/crce_checker.sv]
// Port-level checker for the curve evaluator, bound to the top level.
// Depends on crce_pkg and catmull_rom_curve_eval_top.
`timescale 1ns / 1ps

module crce_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input crce_pkg::crce_item_t   item,
    input logic                   done
);

    // an accepted evaluation occupies the block
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == crce_pkg::OP_EVAL) |=> busy)
        else $error("evaluation transaction did not raise busy");

    // a write transaction leaves busy low and yields no result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == crce_pkg::OP_WRITE) |=> (!busy && !done))
        else $error("write transaction raised busy or done");

    // a result follows a busy period and frees the block
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without preceding busy period");

    // busy only rises from an accepted transaction
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

endmodule

bind catmull_rom_curve_eval_top crce_checker u_crce_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done)
);

[tb/tb_top.sv]
// Self-checking testbench for catmull_rom_curve_eval_top: control-point writes and
// curve evaluations checked against an in-bench spline predictor.
// Depends on crce_pkg and the catmull_rom_curve_eval_top RTL.
`timescale 1ns / 1ps

module tb_top;

    import crce_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_LEN   = 6;
    localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all
    localparam int SETTLE_LEN  = 16;    // longer than an evaluation takes
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 80;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    crce_item_t           item      = '0;
    logic                 done;
    crce_result_t         result;
    logic                 cfg_we    = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;

    // Transactions waiting to be offered, and curve points owed by the block.
    crce_item_t   curve_cmds [$];
    crce_result_t curve_points_due [$];

    // Predictor state: control point table and the point_count register.
    logic signed [COORD_W-1:0] ctrl_pts [3][MAX_POINTS];
    int unsigned               point_count_reg = CNT_RESET;

    // Generator bookkeeping: slots that will have been written by the time
    // queued transactions reach the block.
    bit slot_loaded [MAX_POINTS];

    bit  just_taken   = 1'b0;
    int  gap_left     = 0;
    int  idle_pct     = 0;
    int  errors       = 0;
    int  stall_cycles = 0;

    catmull_rom_curve_eval_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Out-of-range counts act as the nearest legal value.
    function automatic int eff_span(input int unsigned cnt);
        if (cnt < CNT_MIN)
            return CNT_MIN;
        if (cnt > MAX_POINTS)
            return MAX_POINTS;
        return cnt;
    endfunction

    function automatic crce_result_t eval_spline(input logic [U_W-1:0] u_val);
        longint                    n;
        longint                    prod;
        longint                    seg;
        longint                    frac;
        longint                    t;
        longint                    t2;
        longint                    t3;
        longint                    w [NTAPS];
        longint                    acc;
        longint                    r;
        logic signed [COORD_W-1:0] coord [3];
        bit                        clip;
        int                        a;
        int                        k;
        crce_result_t              res;

        n    = eff_span(point_count_reg) - 3;
        prod = longint'(u_val) * n;
        seg  = 1 + (prod >> PARAM_FRAC_BITS);
        frac = prod & ((64'sd1 << PARAM_FRAC_BITS) - 1);
        // parameter at or past 1.0: last segment, fraction 1.0
        if (seg > n)
        begin
            seg  = n;
            frac = 64'sd1 << PARAM_FRAC_BITS;
        end

        t  = frac << (WFRAC - PARAM_FRAC_BITS);
        t2 = (t * t + (64'sd1 << (WFRAC - 1))) >> WFRAC;
        t3 = (t2 * t + (64'sd1 << (WFRAC - 1))) >> WFRAC;

        // doubled basis weights, Q.24
        w[0] = -t3 + 2 * t2 - t;
        w[1] = 3 * t3 - 5 * t2 + (64'sd2 << WFRAC);
        w[2] = -3 * t3 + 4 * t2 + t;
        w[3] = t3 - t2;

        clip = 1'b0;
        for (a = 0; a < 3; a++)
        begin
            acc = 0;
            for (k = 0; k < NTAPS; k++)
                acc += w[k] * longint'(ctrl_pts[a][seg - 1 + k]);
            // halve the doubled weights and round half up
            r = (acc + (64'sd1 << WFRAC)) >>> (WFRAC + 1);
            if (r > 64'sd2147483647)
            begin
                r    = 64'sd2147483647;
                clip = 1'b1;
            end
            if (r < -64'sd2147483648)
            begin
                r    = -64'sd2147483648;
                clip = 1'b1;
            end
            coord[a] = r[COORD_W-1:0];
        end

        res.out_x   = coord[0];
        res.out_y   = coord[1];
        res.out_z   = coord[2];
        res.clipped = clip;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(2097152)) - 32'd1048576;
            7:          return 32'sh7FFF_FFFF;
            8:          return 32'sh8000_0000;
            default:    return 32'($urandom_range(2)) - 32'd1;
        endcase
    endfunction

    task automatic queue_write(input logic [IDX_W-1:0] idx,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z);
        crce_item_t it;
        it.op          = OP_WRITE;
        it.point_index = idx;
        it.in_x        = x;
        it.in_y        = y;
        it.in_z        = z;
        it.u           = U_W'($urandom);
        curve_cmds.push_back(it);
        slot_loaded[idx] = 1'b1;
    endtask

    // Loads any slot the evaluation could touch that was never written.
    task automatic queue_eval(input logic [U_W-1:0] u_val);
        crce_item_t it;
        int         s;
        for (s = 0; s < eff_span(point_count_reg); s++)
            if (!slot_loaded[s])
                queue_write(IDX_W'(s), rand_coord(), rand_coord(), rand_coord());
        it.op          = OP_EVAL;
        it.point_index = IDX_W'($urandom);
        it.in_x        = $urandom;
        it.in_y        = $urandom;
        it.in_z        = $urandom;
        it.u           = u_val;
        curve_cmds.push_back(it);
    endtask

    // Block is idle once everything is taken and every result is back.
    task automatic wait_idle();
        while (curve_cmds.size() != 0 || curve_points_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the oldest pending transaction, idles in bursts
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || just_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (curve_cmds.size() == 0)
            begin
                start <= 1'b0;
            end
            else if ($urandom_range(99) < idle_pct)
            begin
                gap_left = $urandom_range(12, 0);
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                item  <= curve_cmds[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on acceptance, checks each done strobe
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        crce_result_t want;
        just_taken = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                just_taken = 1'b1;
                void'(curve_cmds.pop_front());
                if (item.op == OP_WRITE)
                begin
                    ctrl_pts[0][item.point_index] = item.in_x;
                    ctrl_pts[1][item.point_index] = item.in_y;
                    ctrl_pts[2][item.point_index] = item.in_z;
                end
                else
                begin
                    curve_points_due.push_back(eval_spline(item.u));
                end
            end
            if (done)
            begin
                if (curve_points_due.size() == 0)
                begin
                    report_mismatch("unexpected result, out_x", result.out_x, '0);
                end
                else
                begin
                    want = curve_points_due.pop_front();
                    if (result.out_x !== want.out_x)
                        report_mismatch("out_x", result.out_x, want.out_x);
                    if (result.out_y !== want.out_y)
                        report_mismatch("out_y", result.out_y, want.out_y);
                    if (result.out_z !== want.out_z)
                        report_mismatch("out_z", result.out_z, want.out_z);
                    if (result.clipped !== want.clipped)
                        report_mismatch("clipped", 32'(result.clipped), 32'(want.clipped));
                end
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned      phase_counts [NUM_PHASES];
        int               ph;
        int               i;
        int               n;
        logic [U_W-1:0]   uval;

        phase_counts = '{0, 5, 511, 4, 3, 7, 257, 6, 256, 1, 9, 5};
        phase_counts[10] = $urandom_range(60, 4);

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset count of 4 (one segment).
        // Extremes arranged so the midpoint overshoot saturates x and the overshoot near the segment end saturates y.
        idle_pct = 20;
        queue_write(8'd0, 32'sh8000_0000, 32'sh0000_0000, 32'sh0001_0000);
        queue_write(8'd1, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0002_8000);
        queue_write(8'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh0003_0000);
        queue_write(8'd3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_0000);
        queue_eval(17'd0);          // start of segment: exactly p1
        queue_eval(17'd32768);      // midpoint: overshoot saturates
        queue_eval(17'd65535);      // last fraction below 1.0
        queue_eval(17'd65536);      // exactly 1.0, clamped
        queue_eval(17'd131071);     // far past 1.0, clamped
        queue_eval(17'd1);
        queue_write(8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001);
        queue_write(8'd0, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh7FFF_FFFF);
        queue_eval(17'd16384);
        queue_eval(17'd49152);

        // Random phases, each at its own point_count; the count is changed
        // only with the block drained.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            cfg_wdata <= CNT_W'(phase_counts[ph]);
            cfg_we    <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            point_count_reg = phase_counts[ph];

            if (ph == NUM_PHASES - 1 || ph % 3 == 2)
                idle_pct = 0;
            else
                idle_pct = 10 + $urandom_range(25);

            n = eff_span(point_count_reg) - 3;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 35)
                begin
                    queue_write(IDX_W'($urandom_range(255)), rand_coord(), rand_coord(),
                                rand_coord());
                end
                else
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: uval = U_W'($urandom_range(65536));
                        // segment boundaries
                        6: uval = U_W'((longint'($urandom_range(n)) << PARAM_FRAC_BITS) / n);
                        7:
                        begin
                            case ($urandom_range(3))
                                0:       uval = 17'd0;
                                1:       uval = 17'd1;
                                2:       uval = 17'd65535;
                                default: uval = 17'd65536;
                            endcase
                        end
                        8:       uval = U_W'($urandom_range(131071, 65537));
                        default: uval = U_W'($urandom_range(131071));
                    endcase
                    queue_eval(uval);
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
